### src/shdc_pkg.sv
package shdc_pkg;

    localparam int DATA_BITS = 32;

    // Smallest count of check bits r with 2^r >= DATA_BITS + r + 1.
    function automatic int check_count(int d);
        int r;
        r = 0;
        for (int i = 0; i < 16; i++) begin
            if ((1 << i) < d + i + 1) begin
                r = i + 1;
            end
        end
        return r;
    endfunction

    localparam int CHECK_BITS = check_count(DATA_BITS);
    localparam int CW_BITS    = DATA_BITS + CHECK_BITS + 1;
    localparam int POS_BITS   = 6;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_CORR   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                 cmd;
        logic [DATA_BITS-1:0] data_in;
        logic [CW_BITS-1:0]   codeword_in;
    } t_item;

    typedef struct packed {
        logic [CW_BITS-1:0]   codeword_out;
        logic [DATA_BITS-1:0] data_out;
        t_status              status;
        logic [POS_BITS-1:0]  error_position;
    } t_result;

    // Codeword position of data bit k: the k-th position that is neither
    // zero nor a power of two.
    function automatic int data_pos(int k);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int p = 1; p < CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == k) begin
                    pos = p;
                end
                cnt++;
            end
        end
        return pos;
    endfunction

    // Positions from one upwards whose index has bit i set.
    function automatic logic [CW_BITS-1:0] syn_mask(int i);
        logic [CW_BITS-1:0] m;
        m = '0;
        for (int p = 1; p < CW_BITS; p++) begin
            if (((p >> i) & 1) == 1) begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

### src/shdc_encoder.sv
module shdc_encoder (
    input  logic [shdc_pkg::DATA_BITS-1:0] i_data,
    output logic [shdc_pkg::CW_BITS-1:0]   o_codeword
);
    import shdc_pkg::*;

    logic [CW_BITS-1:0] cw_data;
    logic [CW_BITS-1:0] cw_chk;

    always_comb begin
        cw_data = '0;
        for (int k = 0; k < DATA_BITS; k++) begin
            cw_data[data_pos(k)] = i_data[k];
        end
        cw_chk = cw_data;
        for (int i = 0; i < CHECK_BITS; i++) begin
            cw_chk[1 << i] = ^(cw_data & syn_mask(i));
        end
    end

    // Position zero carries the parity of every other position.
    always_comb begin
        o_codeword    = cw_chk;
        o_codeword[0] = ^cw_chk[CW_BITS-1:1];
    end

endmodule

### src/shdc_decoder.sv
module shdc_decoder (
    input  logic [shdc_pkg::CW_BITS-1:0] i_codeword,
    output shdc_pkg::t_result            o_result
);
    import shdc_pkg::*;

    logic [CHECK_BITS-1:0] syn;
    logic                  mismatch;
    logic                  in_range;
    logic [CW_BITS-1:0]    corrected;
    logic [DATA_BITS-1:0]  data;

    always_comb begin
        for (int i = 0; i < CHECK_BITS; i++) begin
            syn[i] = ^(i_codeword & syn_mask(i));
        end
    end

    assign mismatch  = (^i_codeword[CW_BITS-1:1]) ^ i_codeword[0];
    assign in_range  = (int'(syn) < CW_BITS);
    // A zero syndrome flips position zero, which the data extraction ignores.
    assign corrected = i_codeword ^ (CW_BITS'(1) << syn);

    always_comb begin
        for (int k = 0; k < DATA_BITS; k++) begin
            data[k] = corrected[data_pos(k)];
        end
    end

    always_comb begin
        o_result.codeword_out   = i_codeword;
        o_result.data_out       = '0;
        o_result.status         = ST_CLEAN;
        o_result.error_position = '0;
        if (mismatch) begin
            if (in_range) begin
                o_result.codeword_out   = corrected;
                o_result.data_out       = data;
                o_result.status         = ST_CORR;
                o_result.error_position = POS_BITS'(syn);
            end else begin
                o_result.status = ST_RANGE;
            end
        end else if (syn != '0) begin
            o_result.status = ST_DOUBLE;
        end else begin
            o_result.data_out = data;
        end
    end

endmodule

### src/secded_hamming_codec_unit.sv
// Extended Hamming SECDED codec. One beat is taken in every cycle: busy is
// always low, and a beat accepted with start appears on o_result after the
// input and result registers, marked by o_valid for exactly one cycle. The
// receiver cannot stall, so results must be taken as they come. Each beat
// passes through an input register, one level of XOR trees (encoder or
// syndrome decoder) and a result register; those trees set the clock rate.
module secded_hamming_codec_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  shdc_pkg::t_item   i_item,
    output logic              o_valid,
    output shdc_pkg::t_result o_result
);
    import shdc_pkg::*;

    logic               r_in_valid;
    logic               n_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;
    logic [CW_BITS-1:0] enc_cw;
    t_result            dec_result;

    assign busy       = 1'b0;
    assign n_in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_item <= i_item;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    shdc_encoder u_encoder (
        .i_data     (r_item.data_in),
        .o_codeword (enc_cw)
    );

    shdc_decoder u_decoder (
        .i_codeword (r_item.codeword_in),
        .o_result   (dec_result)
    );

    always_comb begin
        if (r_item.cmd == CMD_ENCODE) begin
            n_result.codeword_out   = enc_cw;
            n_result.data_out       = r_item.data_in;
            n_result.status         = ST_CLEAN;
            n_result.error_position = '0;
        end else begin
            n_result = dec_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result beat without a start two cycles earlier");

    a_corr_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_CORR) |-> (int'(o_result.error_position) < CW_BITS))
        else $error("corrected position lies beyond the codeword");

    a_uncorr_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_DOUBLE || o_result.status == ST_RANGE))
        |-> (o_result.data_out == '0))
        else $error("data present on an uncorrectable beat");

    a_pos_only_on_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_CORR) |-> (o_result.error_position == '0))
        else $error("error position set without a correction");

endmodule
